/* design/tbc_pkg.sv */
// shared types, constants and helpers for the triangle block coverage unit
// used by tbc_emit, triangle_block_coverage and tbc_checker; no dependencies
package tbc_pkg;

    // block geometry
    localparam int BLOCK_SIZE    = 8;
    localparam int QUAD_W        = 4;
    localparam int QUADS_PER_ROW = BLOCK_SIZE / QUAD_W;
    localparam int NUM_QUADS     = BLOCK_SIZE * QUADS_PER_ROW;
    localparam int NUM_EDGES     = 3;

    // field widths
    localparam int COORD_W = 11;
    localparam int TAG_W   = 16;
    localparam int VERT_W  = 16;
    localparam int EDGE_W  = 32;
    localparam int SUBPIX  = 4;

    // fragment kinds
    localparam logic FRAG_FULL = 1'b0;
    localparam logic FRAG_QUAD = 1'b1;

    typedef logic [EDGE_W-1:0]  edge_val_t;
    typedef logic [QUAD_W-1:0]  quad_mask_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [TAG_W-1:0]   tag_t;

    // one classified block handed from the coverage pipeline to the emitter
    typedef struct packed {
        logic                            full;
        quad_mask_t [NUM_QUADS-1:0]      masks;
        coord_t                          bx;
        coord_t                          by;
        tag_t                            tag;
    } cover_item_t;

    // a point lies inside an edge when the edge value is strictly positive
    function automatic logic edge_inside(edge_val_t v);
        return (v != '0) && !v[EDGE_W-1];
    endfunction

endpackage

/* design/tbc_emit.sv */
// fragment emitter: holds the quad masks of one block and sends one fragment per transfer
// depends on tbc_pkg
module tbc_emit
    import tbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cover_item_t in_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frag_kind,
    output coord_t      m_frag_x,
    output coord_t      m_frag_y,
    output quad_mask_t  m_cover_mask,
    output tag_t        m_frag_tag,
    output logic        m_last
);

    localparam int QIDX_W = $clog2(NUM_QUADS);

    logic                       em_valid_reg;
    logic                       em_full_reg;
    logic [NUM_QUADS-1:0]       em_pend_reg;
    quad_mask_t [NUM_QUADS-1:0] em_masks_reg;
    coord_t                     em_bx_reg;
    coord_t                     em_by_reg;
    tag_t                       em_tag_reg;

    logic [NUM_QUADS-1:0] pend_next;
    logic [NUM_QUADS-1:0] cur_onehot;
    logic [NUM_QUADS-1:0] rest;
    logic [QIDX_W-1:0]    cur_idx;
    logic                 cur_last;
    logic                 out_fire;
    logic                 load;
    logic                 em_valid_next;

    // quads of the incoming block that carry any covered pixel
    always_comb begin
        for (int q = 0; q < NUM_QUADS; q++) begin
            pend_next[q] = (in_item.masks[q] != '0);
        end
    end

    // lowest pending quad goes out next
    assign cur_onehot = em_pend_reg & (~em_pend_reg + NUM_QUADS'(1));
    assign rest       = em_pend_reg & ~cur_onehot;

    always_comb begin
        cur_idx = '0;
        for (int q = 0; q < NUM_QUADS; q++) begin
            if (cur_onehot[q]) begin
                cur_idx = cur_idx | QIDX_W'(q);
            end
        end
    end

    assign cur_last = em_full_reg || (rest == '0);
    assign out_fire = em_valid_reg && m_ready;
    assign in_ready = !em_valid_reg || (out_fire && cur_last);
    assign load     = in_valid && in_ready;
    // blocks with nothing to emit are taken and dropped here
    assign em_valid_next = load ? (in_item.full || (pend_next != '0))
                         : (out_fire && cur_last) ? 1'b0 : em_valid_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
        end else begin
            em_valid_reg <= em_valid_next;
        end
    end

    // block payload and pending quads
    always_ff @(posedge aclk) begin
        if (load) begin
            em_full_reg  <= in_item.full;
            em_pend_reg  <= in_item.full ? '0 : pend_next;
            em_masks_reg <= in_item.masks;
            em_bx_reg    <= in_item.bx;
            em_by_reg    <= in_item.by;
            em_tag_reg   <= in_item.tag;
        end else if (out_fire) begin
            em_pend_reg  <= rest;
        end
    end

    // fragment fields, quad index is row then half
    assign m_valid      = em_valid_reg;
    assign m_frag_kind  = em_full_reg ? FRAG_FULL : FRAG_QUAD;
    assign m_frag_x     = em_full_reg ? em_bx_reg
                        : COORD_W'(em_bx_reg + COORD_W'(cur_idx[0]) * COORD_W'(QUAD_W));
    assign m_frag_y     = em_full_reg ? em_by_reg
                        : COORD_W'(em_by_reg + COORD_W'(cur_idx[QIDX_W-1:1]));
    assign m_cover_mask = em_full_reg ? '0 : em_masks_reg[cur_idx];
    assign m_frag_tag   = em_tag_reg;
    assign m_last       = cur_last;

endmodule

/* design/triangle_block_coverage.sv */
// Half-space coverage of one 8x8 pixel block by one triangle. An accepted block
// passes through a five-stage pipeline (edge deltas, corner products, corner sums
// and classification, row and column edge offsets, per-pixel tests) and then the
// fragment emitter, whose registers drive the m_ port. A new block is taken every
// cycle while the emitter keeps up: a rejected block gives no fragment, a block
// that is fully covered gives a single one, and a partly covered block gives one
// quad fragment per quad with any pixel inside, 0 to 16, since the result port
// carries one fragment per transfer.
// depends on tbc_pkg and tbc_emit
module triangle_block_coverage
    import tbc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VERT_W-1:0]  s_vert0_x,
    input  logic signed [VERT_W-1:0]  s_vert0_y,
    input  logic signed [VERT_W-1:0]  s_vert1_x,
    input  logic signed [VERT_W-1:0]  s_vert1_y,
    input  logic signed [VERT_W-1:0]  s_vert2_x,
    input  logic signed [VERT_W-1:0]  s_vert2_y,
    input  logic signed [EDGE_W-1:0]  s_edge_const_a,
    input  logic signed [EDGE_W-1:0]  s_edge_const_b,
    input  logic signed [EDGE_W-1:0]  s_edge_const_c,
    input  logic [COORD_W-1:0]        s_block_x,
    input  logic [COORD_W-1:0]        s_block_y,
    input  logic [TAG_W-1:0]          s_prim_tag,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_frag_kind,
    output logic [COORD_W-1:0]        m_frag_x,
    output logic [COORD_W-1:0]        m_frag_y,
    output logic [QUAD_W-1:0]         m_cover_mask,
    output logic [TAG_W-1:0]          m_frag_tag,
    output logic                      m_last
);

    localparam int DELTA_W = VERT_W + 1;
    localparam int POS_W   = 16;
    localparam int PROD_W  = 2 * DELTA_W;

    typedef logic signed [DELTA_W-1:0] delta_t;

    // ready chain, each stage moves when empty or when the next one moves
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, em_ready;

    // stage 1: edge deltas
    logic      s1_valid_reg;
    delta_t    s1_dx_reg   [NUM_EDGES];
    delta_t    s1_dy_reg   [NUM_EDGES];
    delta_t    s1_dx_next  [NUM_EDGES];
    delta_t    s1_dy_next  [NUM_EDGES];
    edge_val_t s1_c_reg    [NUM_EDGES];
    coord_t    s1_bx_reg, s1_by_reg;
    tag_t      s1_tag_reg;

    // stage 2: corner products
    logic      s2_valid_reg;
    edge_val_t s2_dxy0_reg [NUM_EDGES];
    edge_val_t s2_dxy1_reg [NUM_EDGES];
    edge_val_t s2_dyx0_reg [NUM_EDGES];
    edge_val_t s2_dyx1_reg [NUM_EDGES];
    edge_val_t s2_dxy0_next[NUM_EDGES];
    edge_val_t s2_dxy1_next[NUM_EDGES];
    edge_val_t s2_dyx0_next[NUM_EDGES];
    edge_val_t s2_dyx1_next[NUM_EDGES];
    edge_val_t s2_c_reg    [NUM_EDGES];
    edge_val_t s2_dx16_reg [NUM_EDGES];
    edge_val_t s2_dy16_reg [NUM_EDGES];
    coord_t    s2_bx_reg, s2_by_reg;
    tag_t      s2_tag_reg;
    logic [POS_W-1:0] x0, x1, y0, y1;

    // stage 3: corner classification
    logic      s3_valid_reg;
    logic      s3_full_reg;
    edge_val_t s3_cy0_reg  [NUM_EDGES];
    edge_val_t s3_dx16_reg [NUM_EDGES];
    edge_val_t s3_dy16_reg [NUM_EDGES];
    coord_t    s3_bx_reg, s3_by_reg;
    tag_t      s3_tag_reg;
    edge_val_t s3_cy0_next [NUM_EDGES];
    logic      s3_full_next;
    logic      s2_none;

    // stage 4: row and column offsets
    logic      s4_valid_reg;
    logic      s4_full_reg;
    edge_val_t s4_rowv_reg [NUM_EDGES][BLOCK_SIZE];
    edge_val_t s4_colv_reg [NUM_EDGES][BLOCK_SIZE];
    edge_val_t s4_rowv_next[NUM_EDGES][BLOCK_SIZE];
    edge_val_t s4_colv_next[NUM_EDGES][BLOCK_SIZE];
    coord_t    s4_bx_reg, s4_by_reg;
    tag_t      s4_tag_reg;

    // stage 5: quad masks
    logic        s5_valid_reg;
    cover_item_t s5_item_reg;
    cover_item_t s5_item_next;

    assign s5_ready = !s5_valid_reg || em_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    // edge deltas: v0->v1, v1->v2, v2->v0
    always_comb begin
        s1_dx_next[0] = delta_t'(s_vert0_x) - delta_t'(s_vert1_x);
        s1_dx_next[1] = delta_t'(s_vert1_x) - delta_t'(s_vert2_x);
        s1_dx_next[2] = delta_t'(s_vert2_x) - delta_t'(s_vert0_x);
        s1_dy_next[0] = delta_t'(s_vert0_y) - delta_t'(s_vert1_y);
        s1_dy_next[1] = delta_t'(s_vert1_y) - delta_t'(s_vert2_y);
        s1_dy_next[2] = delta_t'(s_vert2_y) - delta_t'(s_vert0_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_valid) begin
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_c_reg[0] <= s_edge_const_a;
            s1_c_reg[1] <= s_edge_const_b;
            s1_c_reg[2] <= s_edge_const_c;
            s1_bx_reg  <= s_block_x;
            s1_by_reg  <= s_block_y;
            s1_tag_reg <= s_prim_tag;
        end
    end

    // corner positions in 12.4, then the four products per edge
    assign x0 = POS_W'({s1_bx_reg, SUBPIX'(0)});
    assign x1 = POS_W'({(12'(s1_bx_reg) + 12'(BLOCK_SIZE - 1)), SUBPIX'(0)});
    assign y0 = POS_W'({s1_by_reg, SUBPIX'(0)});
    assign y1 = POS_W'({(12'(s1_by_reg) + 12'(BLOCK_SIZE - 1)), SUBPIX'(0)});

    always_comb begin
        logic signed [PROD_W-1:0] p_xy0, p_xy1, p_yx0, p_yx1;
        for (int e = 0; e < NUM_EDGES; e++) begin
            p_xy0 = s1_dx_reg[e] * $signed({1'b0, y0});
            p_xy1 = s1_dx_reg[e] * $signed({1'b0, y1});
            p_yx0 = s1_dy_reg[e] * $signed({1'b0, x0});
            p_yx1 = s1_dy_reg[e] * $signed({1'b0, x1});
            s2_dxy0_next[e] = p_xy0[EDGE_W-1:0];
            s2_dxy1_next[e] = p_xy1[EDGE_W-1:0];
            s2_dyx0_next[e] = p_yx0[EDGE_W-1:0];
            s2_dyx1_next[e] = p_yx1[EDGE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_dxy0_reg <= s2_dxy0_next;
            s2_dxy1_reg <= s2_dxy1_next;
            s2_dyx0_reg <= s2_dyx0_next;
            s2_dyx1_reg <= s2_dyx1_next;
            s2_c_reg    <= s1_c_reg;
            for (int e = 0; e < NUM_EDGES; e++) begin
                s2_dx16_reg[e] <= EDGE_W'({s1_dx_reg[e], SUBPIX'(0)})
                                | {{(EDGE_W-DELTA_W-SUBPIX){s1_dx_reg[e][DELTA_W-1]}},
                                   (DELTA_W + SUBPIX)'(0)};
                s2_dy16_reg[e] <= EDGE_W'({s1_dy_reg[e], SUBPIX'(0)})
                                | {{(EDGE_W-DELTA_W-SUBPIX){s1_dy_reg[e][DELTA_W-1]}},
                                   (DELTA_W + SUBPIX)'(0)};
            end
            s2_bx_reg  <= s1_bx_reg;
            s2_by_reg  <= s1_by_reg;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // corner edge values and trivial reject / accept
    always_comb begin
        logic [3:0] bits;
        s2_none      = 1'b0;
        s3_full_next = 1'b1;
        for (int e = 0; e < NUM_EDGES; e++) begin
            s3_cy0_next[e] = s2_c_reg[e] + s2_dxy0_reg[e] - s2_dyx0_reg[e];
            bits[0] = edge_inside(s3_cy0_next[e]);
            bits[1] = edge_inside(s2_c_reg[e] + s2_dxy0_reg[e] - s2_dyx1_reg[e]);
            bits[2] = edge_inside(s2_c_reg[e] + s2_dxy1_reg[e] - s2_dyx0_reg[e]);
            bits[3] = edge_inside(s2_c_reg[e] + s2_dxy1_reg[e] - s2_dyx1_reg[e]);
            if (bits == 4'h0) begin
                s2_none = 1'b1;
            end
            if (bits != 4'hF) begin
                s3_full_next = 1'b0;
            end
        end
    end

    // rejected blocks leave the pipeline here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg && !s2_none;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_full_reg <= s3_full_next;
            s3_cy0_reg  <= s3_cy0_next;
            s3_dx16_reg <= s2_dx16_reg;
            s3_dy16_reg <= s2_dy16_reg;
            s3_bx_reg   <= s2_bx_reg;
            s3_by_reg   <= s2_by_reg;
            s3_tag_reg  <= s2_tag_reg;
        end
    end

    // row start values and column steps, small constant multiples by shift and add
    always_comb begin
        logic [2:0] sel;
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int i = 0; i < BLOCK_SIZE; i++) begin
                sel = 3'(i);
                s4_rowv_next[e][i] = s3_cy0_reg[e]
                    + ({EDGE_W{sel[0]}} & s3_dx16_reg[e])
                    + ({EDGE_W{sel[1]}} & (s3_dx16_reg[e] << 1))
                    + ({EDGE_W{sel[2]}} & (s3_dx16_reg[e] << 2));
                s4_colv_next[e][i] = ({EDGE_W{sel[0]}} & s3_dy16_reg[e])
                    + ({EDGE_W{sel[1]}} & (s3_dy16_reg[e] << 1))
                    + ({EDGE_W{sel[2]}} & (s3_dy16_reg[e] << 2));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready && s3_valid_reg) begin
            s4_full_reg <= s3_full_reg;
            s4_rowv_reg <= s4_rowv_next;
            s4_colv_reg <= s4_colv_next;
            s4_bx_reg   <= s3_bx_reg;
            s4_by_reg   <= s3_by_reg;
            s4_tag_reg  <= s3_tag_reg;
        end
    end

    // per-pixel tests against every edge, gathered into quad masks
    always_comb begin
        logic hit;
        s5_item_next.full = s4_full_reg;
        s5_item_next.bx   = s4_bx_reg;
        s5_item_next.by   = s4_by_reg;
        s5_item_next.tag  = s4_tag_reg;
        for (int r = 0; r < BLOCK_SIZE; r++) begin
            for (int p = 0; p < BLOCK_SIZE; p++) begin
                hit = 1'b1;
                for (int e = 0; e < NUM_EDGES; e++) begin
                    if (!edge_inside(s4_rowv_reg[e][r] - s4_colv_reg[e][p])) begin
                        hit = 1'b0;
                    end
                end
                s5_item_next.masks[r * QUADS_PER_ROW + p / QUAD_W][p % QUAD_W] = hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_ready) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready && s4_valid_reg) begin
            s5_item_reg <= s5_item_next;
        end
    end

    // fragment output
    tbc_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s5_valid_reg),
        .in_ready     (em_ready),
        .in_item      (s5_item_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frag_kind  (m_frag_kind),
        .m_frag_x     (m_frag_x),
        .m_frag_y     (m_frag_y),
        .m_cover_mask (m_cover_mask),
        .m_frag_tag   (m_frag_tag),
        .m_last       (m_last)
    );

endmodule

/* design/tbc_checker.sv */
// port-level checks on the fragment output of triangle_block_coverage, with bind
// depends on tbc_pkg
module tbc_checker
    import tbc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_frag_kind,
    input logic [COORD_W-1:0] m_frag_x,
    input logic [COORD_W-1:0] m_frag_y,
    input logic [QUAD_W-1:0]  m_cover_mask,
    input logic [TAG_W-1:0]   m_frag_tag,
    input logic               m_last
);

    // a stalled fragment holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frag_kind) && $stable(m_frag_x)
            && $stable(m_frag_y) && $stable(m_cover_mask) && $stable(m_frag_tag)
            && $stable(m_last))
        else $error("fragment changed while stalled");

    // a full block is always a lone fragment with an empty mask
    a_full_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frag_kind == FRAG_FULL) |-> m_last && (m_cover_mask == '0))
        else $error("full block fragment malformed");

    // quad fragments are only sent with some coverage
    a_quad_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frag_kind == FRAG_QUAD) |-> (m_cover_mask != '0))
        else $error("empty quad fragment sent");

    // a following quad of the same block keeps the tag
    a_tag_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last ##1 m_valid |-> $stable(m_frag_tag)
            && (m_frag_kind == FRAG_QUAD))
        else $error("block split across tags");

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind triangle_block_coverage tbc_checker u_tbc_checker (.*);

/* bench/triangle_block_coverage_tb.sv */
// self-checking bench for triangle_block_coverage: blocks from a queue, fragments
// checked in order against a coverage predictor; depends on tbc_pkg and the rtl
`timescale 1ns / 100ps

module triangle_block_coverage_tb
    import tbc_pkg::*;
;

    // one block transfer on the s_ side
    typedef struct packed {
        logic [VERT_W-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
        logic [EDGE_W-1:0] ca, cb, cc;
        coord_t            bx;
        coord_t            by;
        tag_t              tag;
    } tri_item_t;

    // one fragment transfer on the m_ side
    typedef struct packed {
        logic       kind;
        coord_t     x;
        coord_t     y;
        quad_mask_t mask;
        tag_t       tag;
        logic       last;
    } frag_t;

    localparam int N_RANDOM   = 500;
    localparam int TAIL_ITEMS = 60;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_AT   = 320;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [VERT_W-1:0] s_vert0_x = '0, s_vert0_y = '0;
    logic signed [VERT_W-1:0] s_vert1_x = '0, s_vert1_y = '0;
    logic signed [VERT_W-1:0] s_vert2_x = '0, s_vert2_y = '0;
    logic signed [EDGE_W-1:0] s_edge_const_a = '0, s_edge_const_b = '0, s_edge_const_c = '0;
    logic [COORD_W-1:0] s_block_x = '0, s_block_y = '0;
    logic [TAG_W-1:0] s_prim_tag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_frag_kind;
    logic [COORD_W-1:0] m_frag_x, m_frag_y;
    logic [QUAD_W-1:0] m_cover_mask;
    logic [TAG_W-1:0] m_frag_tag;
    logic m_last;

    tri_item_t block_q[$];
    frag_t     frag_q[$];
    tri_item_t drv_item;

    int n_total = 0;
    int items_sent = 0;
    int frags_seen = 0;
    int err_cnt = 0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    bit drain_done = 1'b0;
    int n_full = 0, n_quads = 0, n_reject = 0, n_empty = 0;

    triangle_block_coverage uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vert0_x(s_vert0_x), .s_vert0_y(s_vert0_y),
        .s_vert1_x(s_vert1_x), .s_vert1_y(s_vert1_y),
        .s_vert2_x(s_vert2_x), .s_vert2_y(s_vert2_y),
        .s_edge_const_a(s_edge_const_a), .s_edge_const_b(s_edge_const_b),
        .s_edge_const_c(s_edge_const_c),
        .s_block_x(s_block_x), .s_block_y(s_block_y), .s_prim_tag(s_prim_tag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_frag_kind(m_frag_kind), .m_frag_x(m_frag_x), .m_frag_y(m_frag_y),
        .m_cover_mask(m_cover_mask), .m_frag_tag(m_frag_tag), .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    // strictly positive in 32-bit two's complement
    function automatic logic covers(logic [31:0] v);
        return (v != 32'd0) && !v[31];
    endfunction

    // idling is off in every third stretch of 80 blocks and over the tail
    function automatic logic idle_allowed();
        return (items_sent + TAIL_ITEMS < n_total) && ((items_sent / 80) % 3 != 2);
    endfunction

    // expected fragments of one block, appended to frag_q
    task automatic predict_coverage(input tri_item_t it);
        logic [31:0] px[3], py[3], cst[3], dx[3], dy[3], cy[3];
        logic [31:0] x0, x1, y0, y1, fdy;
        logic [3:0]  hits[3];
        quad_mask_t  mask;
        logic        all_in;
        frag_t       f;
        frag_t       quads[$];
        px[0] = {{16{it.v0x[15]}}, it.v0x};
        py[0] = {{16{it.v0y[15]}}, it.v0y};
        px[1] = {{16{it.v1x[15]}}, it.v1x};
        py[1] = {{16{it.v1y[15]}}, it.v1y};
        px[2] = {{16{it.v2x[15]}}, it.v2x};
        py[2] = {{16{it.v2y[15]}}, it.v2y};
        cst[0] = it.ca;
        cst[1] = it.cb;
        cst[2] = it.cc;
        x0 = {21'd0, it.bx} << SUBPIX;
        x1 = ({21'd0, it.bx} + 32'(BLOCK_SIZE - 1)) << SUBPIX;
        y0 = {21'd0, it.by} << SUBPIX;
        y1 = ({21'd0, it.by} + 32'(BLOCK_SIZE - 1)) << SUBPIX;
        for (int e = 0; e < NUM_EDGES; e++) begin
            dx[e] = px[e] - px[(e + 1) % NUM_EDGES];
            dy[e] = py[e] - py[(e + 1) % NUM_EDGES];
            hits[e][0] = covers(cst[e] + dx[e] * y0 - dy[e] * x0);
            hits[e][1] = covers(cst[e] + dx[e] * y0 - dy[e] * x1);
            hits[e][2] = covers(cst[e] + dx[e] * y1 - dy[e] * x0);
            hits[e][3] = covers(cst[e] + dx[e] * y1 - dy[e] * x1);
        end
        f.tag = it.tag;
        // some edge excludes every corner
        if (hits[0] == 4'h0 || hits[1] == 4'h0 || hits[2] == 4'h0) begin
            n_reject++;
            return;
        end
        // every corner inside every edge
        if (hits[0] == 4'hF && hits[1] == 4'hF && hits[2] == 4'hF) begin
            f.kind = FRAG_FULL;
            f.x    = it.bx;
            f.y    = it.by;
            f.mask = '0;
            f.last = 1'b1;
            frag_q.push_back(f);
            n_full++;
            return;
        end
        // partial block: walk rows, two quads per row
        for (int e = 0; e < NUM_EDGES; e++)
            cy[e] = cst[e] + dx[e] * y0 - dy[e] * x0;
        for (int row = 0; row < BLOCK_SIZE; row++) begin
            for (int half = 0; half < QUADS_PER_ROW; half++) begin
                mask = '0;
                for (int k = 0; k < QUAD_W; k++) begin
                    all_in = 1'b1;
                    for (int e = 0; e < NUM_EDGES; e++) begin
                        fdy = dy[e] << SUBPIX;
                        if (!covers(cy[e] - fdy * 32'(half * QUAD_W + k)))
                            all_in = 1'b0;
                    end
                    mask[k] = all_in;
                end
                if (mask != '0) begin
                    f.kind = FRAG_QUAD;
                    f.x    = it.bx + coord_t'(half * QUAD_W);
                    f.y    = it.by + coord_t'(row);
                    f.mask = mask;
                    f.last = 1'b0;
                    quads.push_back(f);
                end
            end
            for (int e = 0; e < NUM_EDGES; e++)
                cy[e] = cy[e] + (dx[e] << SUBPIX);
        end
        if (quads.size() == 0) begin
            n_empty++;
            return;
        end
        quads[quads.size() - 1].last = 1'b1;
        n_quads += quads.size();
        foreach (quads[i])
            frag_q.push_back(quads[i]);
    endtask

    // triangle whose edge constants put each edge through its two vertices, plus a bias
    function automatic tri_item_t build_tri(coord_t bx, coord_t by, int ax, int ay,
                                            int bvx, int bvy, int cvx, int cvy,
                                            int bias, tag_t tag);
        tri_item_t   it;
        logic [31:0] px[3], py[3], cst[3], dx, dy;
        it.v0x = 16'(ax);
        it.v0y = 16'(ay);
        it.v1x = 16'(bvx);
        it.v1y = 16'(bvy);
        it.v2x = 16'(cvx);
        it.v2y = 16'(cvy);
        px[0] = {{16{it.v0x[15]}}, it.v0x};
        py[0] = {{16{it.v0y[15]}}, it.v0y};
        px[1] = {{16{it.v1x[15]}}, it.v1x};
        py[1] = {{16{it.v1y[15]}}, it.v1y};
        px[2] = {{16{it.v2x[15]}}, it.v2x};
        py[2] = {{16{it.v2y[15]}}, it.v2y};
        for (int e = 0; e < NUM_EDGES; e++) begin
            dx = px[e] - px[(e + 1) % NUM_EDGES];
            dy = py[e] - py[(e + 1) % NUM_EDGES];
            cst[e] = dy * px[e] - dx * py[e] + 32'(bias);
        end
        it.ca  = cst[0];
        it.cb  = cst[1];
        it.cc  = cst[2];
        it.bx  = bx;
        it.by  = by;
        it.tag = tag;
        return it;
    endfunction

    // shape: 0 small, 1 medium, 2 large around the block, 3 wide over the whole range
    function automatic tri_item_t random_tri(int shape);
        coord_t bx, by;
        int     cx, cy, s, j, ax, ay, bvx, bvy, cvx, cvy, t;
        longint area;
        bit     flip;
        if ($urandom_range(0, 9) == 0) begin
            bx = coord_t'($urandom_range(0, 2047));
            by = coord_t'($urandom_range(0, 2047));
        end else begin
            bx = coord_t'($urandom_range(0, 255) * BLOCK_SIZE);
            by = coord_t'($urandom_range(0, 255) * BLOCK_SIZE);
        end
        cx = int'(bx) * 16 + 56;
        cy = int'(by) * 16 + 56;
        case (shape)
            0: s = $urandom_range(16, 160);
            1: s = $urandom_range(160, 800);
            default: s = $urandom_range(1500, 6000);
        endcase
        j = s / 4;
        if (shape == 2) begin
            ax  = cx - s + int'($urandom_range(0, 2 * j)) - j;
            ay  = cy - s + int'($urandom_range(0, 2 * j)) - j;
            bvx = cx + 2 * s + int'($urandom_range(0, 2 * j)) - j;
            bvy = cy - s + int'($urandom_range(0, 2 * j)) - j;
            cvx = cx - s + int'($urandom_range(0, 2 * j)) - j;
            cvy = cy + 2 * s + int'($urandom_range(0, 2 * j)) - j;
        end else if (shape == 3) begin
            ax  = int'($urandom_range(0, 65535)) - 32768;
            ay  = int'($urandom_range(0, 65535)) - 32768;
            bvx = int'($urandom_range(0, 65535)) - 32768;
            bvy = int'($urandom_range(0, 65535)) - 32768;
            cvx = int'($urandom_range(0, 65535)) - 32768;
            cvy = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            ax  = cx + int'($urandom_range(0, 2 * s)) - s;
            ay  = cy + int'($urandom_range(0, 2 * s)) - s;
            bvx = cx + int'($urandom_range(0, 2 * s)) - s;
            bvy = cy + int'($urandom_range(0, 2 * s)) - s;
            cvx = cx + int'($urandom_range(0, 2 * s)) - s;
            cvy = cy + int'($urandom_range(0, 2 * s)) - s;
        end
        // mostly wind so that the interior is positive, sometimes the other way
        area = longint'(ay - bvy) * longint'(ax - cvx) - longint'(ax - bvx) * longint'(ay - cvy);
        flip = ($urandom_range(0, 9) == 0);
        if ((area < 0) != flip) begin
            t = bvx; bvx = cvx; cvx = t;
            t = bvy; bvy = cvy; cvy = t;
        end
        return build_tri(bx, by, ax, ay, bvx, bvy, cvx, cvy,
                         int'($urandom_range(0, 2)) - 1, tag_t'($urandom));
    endfunction

    // every field random over its full width
    function automatic tri_item_t random_noise();
        tri_item_t it;
        it.v0x = 16'($urandom);
        it.v0y = 16'($urandom);
        it.v1x = 16'($urandom);
        it.v1y = 16'($urandom);
        it.v2x = 16'($urandom);
        it.v2y = 16'($urandom);
        it.ca  = $urandom;
        it.cb  = $urandom;
        it.cc  = $urandom;
        it.bx  = coord_t'($urandom_range(0, 2047));
        it.by  = coord_t'($urandom_range(0, 2047));
        it.tag = tag_t'($urandom);
        return it;
    endfunction

    // hand-made block with free edge constants
    function automatic tri_item_t raw_tri(int ax, int ay, int bvx, int bvy, int cvx, int cvy,
                                          int ca, int cb, int cc, int bx, int by, int tag);
        tri_item_t it;
        it.v0x = 16'(ax);
        it.v0y = 16'(ay);
        it.v1x = 16'(bvx);
        it.v1y = 16'(bvy);
        it.v2x = 16'(cvx);
        it.v2y = 16'(cvy);
        it.ca  = 32'(ca);
        it.cb  = 32'(cb);
        it.cc  = 32'(cc);
        it.bx  = coord_t'(bx);
        it.by  = coord_t'(by);
        it.tag = tag_t'(tag);
        return it;
    endfunction

    // driver: one transfer per handshake, random gaps, one drain pause
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_coverage(drv_item);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (!drain_done && items_sent >= DRAIN_AT) begin
                    if (frag_q.size() == 0)
                        drain_done = 1'b1;
                    s_valid <= 1'b0;
                end else if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_valid <= 1'b0;
                end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
                    gap_cnt = $urandom_range(1, 9) - 1;
                    s_valid <= 1'b0;
                end else if (block_q.size() > 0) begin
                    drv_item = block_q.pop_front();
                    s_vert0_x      <= drv_item.v0x;
                    s_vert0_y      <= drv_item.v0y;
                    s_vert1_x      <= drv_item.v1x;
                    s_vert1_y      <= drv_item.v1y;
                    s_vert2_x      <= drv_item.v2x;
                    s_vert2_y      <= drv_item.v2y;
                    s_edge_const_a <= drv_item.ca;
                    s_edge_const_b <= drv_item.cb;
                    s_edge_const_c <= drv_item.cc;
                    s_block_x      <= drv_item.bx;
                    s_block_y      <= drv_item.by;
                    s_prim_tag     <= drv_item.tag;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each fragment transfer, then decide the next m_ready
    always @(posedge aclk) begin
        frag_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_frag_kind, m_frag_x, m_frag_y, m_cover_mask, m_frag_tag, m_last};
                frags_seen++;
                if (frag_q.size() == 0) begin
                    if (err_cnt < 20)
                        $display("%0t: unexpected fragment kind=%0d x=%0d y=%0d mask=%h tag=%h",
                                 $time, got.kind, got.x, got.y, got.mask, got.tag);
                    err_cnt++;
                end else begin
                    want = frag_q.pop_front();
                    if (got !== want) begin
                        if (err_cnt < 20)
                            $display({"%0t: fragment mismatch, expected kind=%0d x=%0d y=%0d ",
                                      "mask=%h tag=%h last=%0d, actual kind=%0d x=%0d y=%0d ",
                                      "mask=%h tag=%h last=%0d"},
                                     $time, want.kind, want.x, want.y, want.mask, want.tag,
                                     want.last, got.kind, got.x, got.y, got.mask, got.tag,
                                     got.last);
                        err_cnt++;
                    end
                end
            end
            // long hold-off once, otherwise short random stalls
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_cnt = HOLD_LEN - 1;
                m_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // reset, stimulus and end of run
    initial begin
        // partial block where the edges pass opposite corners but no pixel is inside both
        block_q.push_back(raw_tri(0, 0, 1, -1, 0, 0, 1, -223, 1, 0, 0, 16'h0000));
        // degenerate triangle, constants at the extremes
        block_q.push_back(raw_tri(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 2047, 2047, 16'hFFFF));
        block_q.push_back(raw_tri(0, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                                  32'h80000000, 0, 0, 16'h0001));
        block_q.push_back(raw_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1024, 1024, 16'h8000));
        // full-width vertices, both windings
        block_q.push_back(build_tri(0, 0, -32768, -32768, 32767, -32768, -32768, 32767,
                                    0, 16'h00FF));
        block_q.push_back(build_tri(2040, 2040, 32767, 32767, -32768, 32767, 32767,
                                    -32768, 0, 16'hFF00));
        block_q.push_back(build_tri(1024, 1024, -32768, 32767, 32767, 32767, -32768,
                                    -32768, 1, 16'h5A5A));
        // a block inside a reversed triangle, then a small triangle in the block in both windings
        block_q.push_back(build_tri(512, 512, 5000, 5000, 14000, 5000, 5000, 14000,
                                    0, 16'h1234));
        block_q.push_back(build_tri(64, 64, 1030, 1030, 1130, 1040, 1040, 1130,
                                    0, 16'h2345));
        block_q.push_back(build_tri(64, 64, 1030, 1030, 1040, 1130, 1130, 1040,
                                    0, 16'h3456));
        // all but the far pixel covered near the top corner: 16 quads, x and y wrap
        block_q.push_back(raw_tri(0, 0, 1, -1, 0, 0, 65640, 0, 1, 2044, 2045, 16'hA5A5));
        block_q.push_back(raw_tri(0, 0, 1, -1, 0, 0, 224, 0, 1, 0, 0, 16'h0F0F));
        // corner not on the 8-pixel grid
        block_q.push_back(build_tri(1003, 517, 16000, 8200, 16150, 8280, 16060, 8400,
                                    0, 16'hC3C3));
        block_q.push_back(raw_tri(0, 0, 1, -1, 0, 0, 33000, -1, 1, 1021, 11, 16'h7777));
        for (int i = 0; i < 4; i++)
            block_q.push_back(random_tri(i));
        // random part: mostly well-formed triangles, some noise
        for (int i = 0; i < N_RANDOM; i++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 25)
                block_q.push_back(random_tri(0));
            else if (sel < 50)
                block_q.push_back(random_tri(1));
            else if (sel < 70)
                block_q.push_back(random_tri(2));
            else if (sel < 85)
                block_q.push_back(random_tri(3));
            else
                block_q.push_back(random_noise());
        end
        n_total = block_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_sent < n_total || frag_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("sent %0d blocks: %0d full-block and %0d quad fragments, %0d rejected",
                 items_sent, n_full, n_quads, n_reject);
        $display("%0d partial blocks without a covered quad, %0d fragments checked",
                 n_empty, frags_seen);
        if (err_cnt == 0 && frag_q.size() == 0) begin
            $display("triangle_block_coverage verification clean");
        end else begin
            $display("triangle_block_coverage verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("triangle_block_coverage verification failed");
        $finish;
    end

endmodule
